// File: rtl/core/gibbs_coefficient_sweep_macros.svh
// Assertion macros for the coefficient sweep block.
// Included by the top level; SYNTH selects the empty bodies.
`ifndef GIBBS_COEFFICIENT_SWEEP_MACROS_SVH
`define GIBBS_COEFFICIENT_SWEEP_MACROS_SVH
`ifndef SYNTH
`define GCS_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`define GCS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define GCS_ASSERT_IMPL(lbl, pre, post, msg)
`define GCS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: rtl/core/gcs_pkg.sv
// Shared types, codes and helpers of the coefficient sweep block.
// No dependencies; used by every module under rtl/core.
package gcs_pkg;

	localparam int MAX_ROWS  = 256;
	localparam int MAX_COLS  = 64;
	localparam int FRAC_BITS = 20;
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int XADDR_W   = ROW_W + COL_W;
	localparam int DATA_W    = 32;
	localparam int MUL_W     = 34;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int DEN_W     = 44;
	localparam int NUM_W     = 64;
	localparam int STEP_W    = 7;

	localparam logic [2:0] FN_LOAD_RES  = 3'd0;
	localparam logic [2:0] FN_LOAD_X    = 3'd1;
	localparam logic [2:0] FN_LOAD_COL  = 3'd2;
	localparam logic [2:0] FN_UPDATE    = 3'd3;
	localparam logic [2:0] FN_READ_RES  = 3'd4;
	localparam logic [2:0] FN_READ_COEF = 3'd5;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_ZERO_PRIOR = 2'd1;
	localparam logic [1:0] STAT_SAT        = 2'd2;

	localparam logic [1:0] REG_ROWS = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;
	localparam logic [1:0] REG_INV  = 2'd2;
	localparam logic [1:0] REG_UNIT = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE, S_FETCH, S_DECIDE, S_DOT, S_XB, S_T, S_TS, S_RHS, S_XS,
		S_DIV_PREC, S_MEAN_GO, S_DIV_MEAN, S_VAR_GO, S_DIV_VAR,
		S_SQRT_GO, S_SQRT_W, S_NOISE, S_NEW, S_UPD, S_DONE
	} seq_state_t;

	typedef enum logic {DIV_OP_DIV, DIV_OP_SQRT} div_op_t;

	typedef struct packed {
		logic    start;
		div_op_t op;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_rsp_t;

	typedef struct packed {
		logic               sat;
		logic signed [31:0] v;
	} sat32_t;

	function automatic sat32_t sat32(input logic signed [63:0] x);
		sat32_t r;
		if (x > 64'sd2147483647) begin
			r.sat = 1'b1;
			r.v   = 32'sh7FFFFFFF;
		end else if (x < -64'sd2147483648) begin
			r.sat = 1'b1;
			r.v   = 32'sh80000000;
		end else begin
			r.sat = 1'b0;
			r.v   = x[31:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/gcs_mul.sv
// Shared signed multiplier with a registered product.
// Depends on gcs_pkg for operand widths.
module gcs_mul (
	input  logic                                clk,
	input  logic signed [gcs_pkg::MUL_W-1:0]    a,
	input  logic signed [gcs_pkg::MUL_W-1:0]    b,
	output logic signed [gcs_pkg::PROD_W-1:0]   p
);
	import gcs_pkg::*;

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;
endmodule

// File: rtl/core/gcs_divsqrt.sv
// Iterative restoring divider and integer square root, one bit a cycle.
// Depends on gcs_pkg for the control structs and widths.
module gcs_divsqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gcs_pkg::div_ctl_t              ctl,
	input  logic [gcs_pkg::NUM_W-1:0]      num,
	input  logic [gcs_pkg::DEN_W-1:0]      den,
	output gcs_pkg::div_rsp_t              rsp,
	output logic [gcs_pkg::NUM_W-1:0]      quo
);
	import gcs_pkg::*;

	localparam int REM_W = DEN_W + 2;
	localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(NUM_W);
	localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(NUM_W / 2);

	logic [NUM_W-1:0]  num_q, quo_q;
	logic [REM_W-1:0]  rem_q, rem_sh, trial;
	logic [DEN_W-1:0]  den_q;
	div_op_t           op_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q, done_q, take;

	always_comb begin
		if (op_q == DIV_OP_SQRT) begin
			rem_sh = {rem_q[REM_W-3:0], num_q[NUM_W-1 -: 2]};
			trial  = {quo_q[REM_W-3:0], 2'b01};
		end else begin
			rem_sh = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
			trial  = {2'b00, den_q};
		end
		take = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (ctl.op == DIV_OP_SQRT) ? SQRT_STEPS : DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= num;
			den_q <= den;
			op_q  <= ctl.op;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? (rem_sh - trial) : rem_sh;
			quo_q <= {quo_q[NUM_W-2:0], take};
			num_q <= (op_q == DIV_OP_SQRT) ? (num_q << 2) : (num_q << 1);
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign quo      = quo_q;
endmodule

// File: rtl/core/gibbs_coefficient_sweep.sv
// Top level of the coefficient sweep: stores, sequencer and datapath.
// Depends on gcs_pkg, gcs_mul, gcs_divsqrt and the assertion macro header.
//
//   channel   direction  handshake            payload
//   request   in         in_valid / in_ready  func row col value prior_var col_sumsq
//   result    out        out_valid/out_ready  result_value status
//   config    in         cfg_we               cfg_index cfg_data
//
// An update makes two streamed passes over nrows rows, nrows being rows_in_use
// capped at MAX_ROWS, through the shared multiplier, plus three 64-step divisions
// and a 32-step square root.
// Reset clears control only; the stores hold garbage until written.
// A finished result waits in the output register; the next request is
// taken meanwhile, and the sequencer holds in its last state until the result moves.
`include "gibbs_coefficient_sweep_macros.svh"
module gibbs_coefficient_sweep (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [7:0]  row,
	input  logic [5:0]  col,
	input  logic signed [31:0] value,
	input  logic [30:0] prior_var,
	input  logic [30:0] col_sumsq,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] result_value,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data
);
	import gcs_pkg::*;

	localparam int ACC_W  = 52;
	localparam int RHS_W  = 44;
	localparam int XS_W   = 42;
	localparam int MEAN_W = 42;
	localparam int SD_W   = 31;
	localparam int DIFF_W = 33;
	localparam logic [NUM_W-1:0] ONE_Q    = NUM_W'(1) << FRAC_BITS;
	localparam logic [NUM_W-1:0] PREC_NUM = NUM_W'(1) << (2 * FRAC_BITS);
	localparam logic [NUM_W-1:0] VAR_NUM  = NUM_W'(1) << (3 * FRAC_BITS);
	localparam logic [NUM_W-1:0] MEAN_CAP = NUM_W'(1) << (2 * FRAC_BITS);

	// configuration
	logic [8:0]  rows_q;
	logic [6:0]  cols_q;
	logic [30:0] inv_q;
	logic        unit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 9'(MAX_ROWS);
			cols_q <= 7'(MAX_COLS);
			inv_q  <= 31'(ONE_Q);
			unit_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS: rows_q <= cfg_data[8:0];
				REG_COLS: cols_q <= cfg_data[6:0];
				REG_INV:  inv_q  <= cfg_data;
				REG_UNIT: unit_q <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	logic [8:0] nrows;
	logic [6:0] ncols;
	assign nrows = (rows_q > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : rows_q;
	assign ncols = (cols_q > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cols_q;

	seq_state_t state_q, state_n;
	logic       accept;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// latched request
	logic [2:0]         func_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic signed [31:0] z_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			row_q  <= row;
			col_q  <= col;
			z_q    <= value;
		end
	end

	// row pass pipeline
	logic [8:0]       cnt_q;
	logic             rv_s1, pv_s2;
	logic [ROW_W-1:0] i_s1, i_s2;
	logic signed [31:0] res_s2;
	logic             in_pass, pass_done;
	assign in_pass   = (state_q == S_DOT) || (state_q == S_UPD);
	assign pass_done = (cnt_q == nrows) && !rv_s1 && !pv_s2;

	// stores
	logic signed [31:0] res_mem  [MAX_ROWS];
	logic signed [31:0] x_mem    [MAX_ROWS * MAX_COLS];
	logic signed [31:0] coef_mem [MAX_COLS];
	logic [30:0]        pv_mem   [MAX_COLS];
	logic [30:0]        ss_mem   [MAX_COLS];
	logic signed [31:0] res_rd_q, x_rd_q, coef_rd_q;
	logic [30:0]        pv_rd_q, ss_rd_q;

	logic               res_we, coef_we, upd_wr, coef_upd;
	logic [ROW_W-1:0]   res_waddr, res_raddr;
	logic signed [31:0] res_wdata, coef_wdata;
	logic [COL_W-1:0]   coef_waddr;
	sat32_t             res_new;
	logic signed [31:0] newv_q;

	assign upd_wr     = (state_q == S_UPD) && pv_s2;
	assign coef_upd   = (state_q == S_UPD) && pass_done;
	assign res_we     = (accept && func == FN_LOAD_RES) || upd_wr;
	assign res_waddr  = upd_wr ? i_s2 : row;
	assign res_wdata  = upd_wr ? res_new.v : value;
	assign res_raddr  = in_pass ? cnt_q[ROW_W-1:0] : row_q;
	assign coef_we    = (accept && func == FN_LOAD_COL) || coef_upd;
	assign coef_waddr = coef_upd ? col_q : col;
	assign coef_wdata = coef_upd ? newv_q : value;

	always_ff @(posedge clk) begin
		if (res_we)
			res_mem[res_waddr] <= res_wdata;
		res_rd_q <= res_mem[res_raddr];
		if (accept && func == FN_LOAD_X)
			x_mem[{col, row}] <= value;
		x_rd_q <= x_mem[{col_q, cnt_q[ROW_W-1:0]}];
		if (coef_we)
			coef_mem[coef_waddr] <= coef_wdata;
		if (accept && func == FN_LOAD_COL) begin
			pv_mem[col] <= prior_var;
			ss_mem[col] <= col_sumsq;
		end
		coef_rd_q <= coef_mem[col_q];
		pv_rd_q   <= pv_mem[col_q];
		ss_rd_q   <= ss_mem[col_q];
	end

	// shared units
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod, prod_sh;
	div_ctl_t                 div_ctl;
	div_rsp_t                 div_rsp;
	logic [NUM_W-1:0]         div_num, div_q;
	logic [DEN_W-1:0]         div_den;

	gcs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

	gcs_divsqrt u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .num(div_num),
		.den(div_den), .rsp(div_rsp), .quo(div_q)
	);

	assign prod_sh = prod >>> FRAC_BITS;

	// update registers
	logic signed [31:0]     bk_q, t_q;
	logic [30:0]            vb_q, x2_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [RHS_W-1:0]  rhs_q;
	logic [RHS_W-1:0]         mag;
	logic [XS_W-1:0]          xs_q;
	logic [DEN_W-1:0]         c_q, c_sum;
	logic signed [MEAN_W-1:0] mean_q;
	logic [SD_W-1:0]          sd_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic                     sat_q;
	logic signed [31:0]       rv_q;
	logic [1:0]               st_q;
	logic                     go_update;
	sat32_t                   t_new, v_new;

	assign mag   = rhs_q[RHS_W-1] ? RHS_W'(-rhs_q) : RHS_W'(rhs_q);
	assign c_sum = DEN_W'(xs_q) + DEN_W'(div_q[2*FRAC_BITS:0]);
	assign t_new = sat32(64'(acc_q) + 64'(prod_sh[63:0]));
	assign v_new = sat32(64'(mean_q) + 64'(prod_sh[63:0]));
	assign res_new = sat32(64'(res_s2) + 64'(prod_sh[63:0]));
	assign go_update = (func_q == FN_UPDATE) && ({1'b0, col_q} < ncols) && (pv_rd_q != '0);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE:     if (in_valid) state_n = S_FETCH;
			S_FETCH:    state_n = S_DECIDE;
			S_DECIDE:   state_n = go_update ? S_DOT : S_DONE;
			S_DOT:      if (pass_done) state_n = S_XB;
			S_XB:       state_n = S_T;
			S_T:        state_n = S_TS;
			S_TS:       state_n = S_RHS;
			S_RHS:      state_n = S_XS;
			S_XS:       state_n = S_DIV_PREC;
			S_DIV_PREC: if (div_rsp.done) state_n = S_MEAN_GO;
			S_MEAN_GO:  state_n = S_DIV_MEAN;
			S_DIV_MEAN: if (div_rsp.done) state_n = S_VAR_GO;
			S_VAR_GO:   state_n = S_DIV_VAR;
			S_DIV_VAR:  if (div_rsp.done) state_n = S_SQRT_GO;
			S_SQRT_GO:  state_n = S_SQRT_W;
			S_SQRT_W:   if (div_rsp.done) state_n = S_NOISE;
			S_NOISE:    state_n = S_NEW;
			S_NEW:      state_n = S_UPD;
			S_UPD:      if (pass_done) state_n = S_DONE;
			S_DONE:     if (!out_valid || out_ready) state_n = S_IDLE;
			default:    state_n = S_IDLE;
		endcase
	end

	// unit operand selection
	always_comb begin
		mul_a       = '0;
		mul_b       = '0;
		div_ctl     = '{start: 1'b0, op: DIV_OP_DIV};
		div_num     = '0;
		div_den     = c_q;
		case (state_q)
			S_DOT: begin
				mul_a = MUL_W'(res_rd_q);
				mul_b = MUL_W'(x_rd_q);
			end
			S_XB: begin
				mul_a = MUL_W'({1'b0, x2_q});
				mul_b = MUL_W'(bk_q);
			end
			S_TS: begin
				mul_a = MUL_W'(t_q);
				mul_b = MUL_W'({1'b0, inv_q});
			end
			S_RHS: begin
				mul_a = MUL_W'({1'b0, x2_q});
				mul_b = MUL_W'({1'b0, inv_q});
			end
			S_XS: begin
				div_ctl.start = 1'b1;
				div_num       = PREC_NUM;
				div_den       = DEN_W'(vb_q);
			end
			S_MEAN_GO: begin
				div_ctl.start = 1'b1;
				div_num       = NUM_W'(mag) << FRAC_BITS;
			end
			S_VAR_GO: begin
				div_ctl.start = 1'b1;
				div_num       = VAR_NUM;
			end
			S_SQRT_GO: begin
				div_ctl = '{start: 1'b1, op: DIV_OP_SQRT};
				div_num = div_q;
			end
			S_NOISE: begin
				mul_a = MUL_W'({1'b0, sd_q});
				mul_b = MUL_W'(z_q);
			end
			S_UPD: begin
				mul_a = MUL_W'(diff_q);
				mul_b = MUL_W'(x_rd_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			cnt_q     <= '0;
			rv_s1     <= 1'b0;
			pv_s2     <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_DONE && (!out_valid || out_ready))
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			pv_s2 <= rv_s1;
			if (state_q == S_DECIDE || state_q == S_NEW)
				cnt_q <= '0;
			if (in_pass && cnt_q < nrows) begin
				cnt_q <= cnt_q + 1'b1;
				rv_s1 <= 1'b1;
			end else begin
				rv_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_s1   <= cnt_q[ROW_W-1:0];
		i_s2   <= i_s1;
		res_s2 <= res_rd_q;
		if (state_q == S_DONE && (!out_valid || out_ready)) begin
			result_value <= rv_q;
			status       <= st_q;
		end
		case (state_q)
			S_DECIDE: begin
				bk_q  <= coef_rd_q;
				vb_q  <= pv_rd_q;
				x2_q  <= unit_q ? 31'(ONE_Q) : ss_rd_q;
				acc_q <= '0;
				sat_q <= 1'b0;
				st_q  <= STAT_OK;
				case (func_q)
					FN_UPDATE: begin
						rv_q <= coef_rd_q;
						if ({1'b0, col_q} < ncols && pv_rd_q == '0)
							st_q <= STAT_ZERO_PRIOR;
					end
					FN_READ_RES:  rv_q <= res_rd_q;
					FN_READ_COEF: rv_q <= coef_rd_q;
					default:      rv_q <= '0;
				endcase
			end
			S_DOT: if (pv_s2) acc_q <= acc_q + ACC_W'(prod_sh);
			S_T: begin
				t_q <= t_new.v;
				if (t_new.sat) sat_q <= 1'b1;
			end
			S_RHS: rhs_q <= RHS_W'(prod_sh);
			S_XS:  xs_q  <= XS_W'(prod >> FRAC_BITS);
			S_DIV_PREC: if (div_rsp.done) c_q <= (c_sum == '0) ? DEN_W'(1) : c_sum;
			S_DIV_MEAN: if (div_rsp.done) begin
				// clamp the mean magnitude at the cap
				if (div_q > MEAN_CAP) begin
					sat_q  <= 1'b1;
					mean_q <= rhs_q[RHS_W-1] ? -MEAN_W'(MEAN_CAP) : MEAN_W'(MEAN_CAP);
				end else begin
					mean_q <= rhs_q[RHS_W-1] ? -MEAN_W'(div_q) : MEAN_W'(div_q);
				end
			end
			S_SQRT_W: if (div_rsp.done) sd_q <= div_q[SD_W-1:0];
			S_NEW: begin
				newv_q <= v_new.v;
				diff_q <= DIFF_W'(bk_q) - DIFF_W'(v_new.v);
				if (v_new.sat) sat_q <= 1'b1;
			end
			S_UPD: begin
				if (upd_wr && res_new.sat) sat_q <= 1'b1;
				if (pass_done) begin
					rv_q <= newv_q;
					st_q <= (sat_q || (upd_wr && res_new.sat)) ? STAT_SAT : STAT_OK;
				end
			end
			default: ;
		endcase
	end

	`GCS_ASSERT_IMPL(a_div_done_waited, div_rsp.done, state_q == S_DIV_PREC || state_q == S_DIV_MEAN || state_q == S_DIV_VAR || state_q == S_SQRT_W, "divider finished outside a wait state")
	`GCS_ASSERT_IMPL(a_pipe_in_pass, pv_s2, state_q == S_DOT || state_q == S_UPD, "row product left its pass")
	`GCS_ASSERT_NEXT(a_one_request, accept, !in_ready, "second request taken while one is in flight")
endmodule
